// ===== hw/rtl/chma_pkg.sv =====
`default_nettype none
package chma_pkg;

	localparam int WINDOW_LEN   = 10;
	localparam int CORDIC_STEPS = 16;
	localparam int WIN_AW       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W        = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W        = 16 + $clog2(WINDOW_LEN + 1);
	// cordic datapath: 16 bit magnitude scaled by 256, gain below 1.65
	localparam int CW           = 28;
	localparam int ZW           = 24;

	localparam logic [15:0] FULL_CIRCLE   = 16'd46080;
	localparam logic [15:0] HALF_CIRCLE   = 16'd23040;
	localparam logic [15:0] QUARTER       = 16'd11520;
	localparam logic [15:0] THREE_QUARTER = 16'd34560;
	localparam logic [ZW-1:0] DEG90_FINE  = 24'd2949120;

	// reciprocal for the window divide: q = (v * RECIP) >> RECIP_SH, then one fixup
	localparam int RECIP_SH = 32;
	localparam logic [32:0] RECIP = 33'((64'd1 << RECIP_SH) / WINDOW_LEN);

	typedef enum logic [1:0] {
		QD_PP = 2'd0,
		QD_NP = 2'd1,
		QD_NN = 2'd2,
		QD_PN = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
	} in_t;

	typedef struct packed {
		logic [15:0] heading;
		logic [15:0] mean_heading;
		logic        mean_valid;
	} out_t;

	// side info carried along the cordic pipe
	typedef struct packed {
		logic        axis;
		logic [15:0] axis_heading;
		quad_t       quad;
	} side_t;

	// atan(2^-i) in 1/32768 degree
	function automatic logic [ZW-1:0] ang(input int i);
		case (i)
			0: ang = 24'd1474560;  1: ang = 24'd870484;  2: ang = 24'd459940;
			3: ang = 24'd233473;   4: ang = 24'd117189;  5: ang = 24'd58652;
			6: ang = 24'd29333;    7: ang = 24'd14667;   8: ang = 24'd7334;
			9: ang = 24'd3667;     10: ang = 24'd1833;   11: ang = 24'd917;
			12: ang = 24'd458;     13: ang = 24'd229;    14: ang = 24'd115;
			15: ang = 24'd57;      16: ang = 24'd29;     17: ang = 24'd14;
			18: ang = 24'd7;       19: ang = 24'd4;      20: ang = 24'd2;
			21: ang = 24'd1;
			default: ang = '0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/compass_heading_moving_average.sv =====
// compass heading with sliding window mean
// in channel: in_valid/in_ready carry one request {mag_x, mag_y}, signed 16 bit
// out channel: out_valid/out_ready carry {heading, mean_heading, mean_valid}
// heading in 1/128 degree, 0..46079; mean_valid stays 0 until the window has
// held WINDOW_LEN headings, then mean_heading is the rounded window mean
// throughput: one request per cycle unless the output stalls, set by the fully
// pipelined cordic (one stage per step) and the read-modify-write of the window
// ram; a request passes the cordic setup, step and mapping registers and window
// stages 1 to 4 to out_valid; the whole pipe advances only when the output
// register is free or taken; a stalled receiver holds the pipe and drops
// in_ready, nothing is lost; reset clears the fill count, running sum and all
// valid flags; the ram is not cleared, as an entry is used only once written
`default_nettype none
module compass_heading_moving_average (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire chma_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output chma_pkg::out_t      out_data
);
	import chma_pkg::*;

	logic en;
	logic h_vld;
	logic [15:0] h;

	// advance whenever the output slot is empty or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	chma_cordic u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (in_valid && in_ready),
		.in_d        (in_data),
		.out_vld     (h_vld),
		.out_heading (h)
	);

	chma_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (h_vld),
		.in_heading (h),
		.out_vld    (out_valid),
		.out_d      (out_data)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/chma_ram.sv =====
`default_nettype none
module chma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/chma_cordic.sv =====
`default_nettype none
// pipelined heading front end: one stage for setup, one per cordic step, one for mapping
module chma_cordic (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire chma_pkg::in_t in_d,
	output logic               out_vld,
	output logic        [15:0] out_heading
);
	import chma_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic                 vld_q  [N+2];
	logic signed [CW-1:0] x_q    [N+1];
	logic signed [CW-1:0] y_q    [N+1];
	logic signed [ZW:0]   z_q    [N+1];
	side_t                side_q [N+1];
	logic [15:0]          head_q;

	// setup stage: magnitudes, quadrant, axis cases
	side_t             side_in;
	logic signed [16:0] ax, ay;
	always_comb begin
		ax = in_d.mag_x[15] ? -17'(in_d.mag_x) : 17'(in_d.mag_x);
		ay = in_d.mag_y[15] ? -17'(in_d.mag_y) : 17'(in_d.mag_y);
		side_in.axis = (in_d.mag_x == 0) || (in_d.mag_y == 0);
		if (in_d.mag_x == 0 && in_d.mag_y == 0) side_in.axis_heading = '0;
		else if (in_d.mag_x == 0)
			side_in.axis_heading = in_d.mag_y[15] ? THREE_QUARTER : QUARTER;
		else side_in.axis_heading = in_d.mag_x[15] ? HALF_CIRCLE : '0;
		case ({in_d.mag_x[15], in_d.mag_y[15]})
			2'b00:   side_in.quad = QD_PP;
			2'b10:   side_in.quad = QD_NP;
			2'b11:   side_in.quad = QD_NN;
			default: side_in.quad = QD_PN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N + 2; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_vld;
			for (int i = 1; i < N + 2; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= CW'(ax) <<< 8;
			y_q[0]    <= CW'(ay) <<< 8;
			z_q[0]    <= '0;
			side_q[0] <= side_in;
		end
	end

	// cordic steps, arithmetic shift is floor shift
	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i+1] <= side_q[i];
				if (!y_q[i][CW-1]) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + $signed({1'b0, ang(i)});
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - $signed({1'b0, ang(i)});
				end
			end
		end
	end

	// clamp, round to 1/128 degree, map quadrant
	logic [ZW-1:0] zc;
	logic [15:0]   a, h;
	logic [16:0]   hs;
	always_comb begin
		if (z_q[N][ZW]) zc = '0;
		else if (z_q[N][ZW-1:0] > DEG90_FINE) zc = DEG90_FINE;
		else zc = z_q[N][ZW-1:0];
		a = 16'((zc + ZW'(128)) >> 8);
		case (side_q[N].quad)
			QD_PP:   hs = 17'(a);
			QD_NP:   hs = 17'(HALF_CIRCLE) - 17'(a);
			QD_NN:   hs = 17'(HALF_CIRCLE) + 17'(a);
			default: hs = 17'(FULL_CIRCLE) - 17'(a);
		endcase
		if (hs >= 17'(FULL_CIRCLE)) hs = hs - 17'(FULL_CIRCLE);
		h = side_q[N].axis ? side_q[N].axis_heading : hs[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) head_q <= h;
	end

	assign out_vld     = vld_q[N+1];
	assign out_heading = head_q;

endmodule
`default_nettype wire

// ===== hw/rtl/chma_window.sv =====
`default_nettype none
// sliding window: circular store in ram, running sum, reciprocal mean
module chma_window (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_vld,
	input  wire logic [15:0] in_heading,
	output logic             out_vld,
	output chma_pkg::out_t   out_d
);
	import chma_pkg::*;

	logic [CNT_W-1:0]  fill_q;
	logic [WIN_AW-1:0] ptr_q;
	logic [SUM_W-1:0]  sum_q;
	logic              full;
	logic [15:0]       old_data;

	assign full = (fill_q == CNT_W'(WINDOW_LEN));

	// stage 1: read oldest entry at pointer; written entry is read WINDOW_LEN samples later
	logic              v_s1, full_s1;
	logic [15:0]       h_s1;
	logic [WIN_AW-1:0] ptr_s1;

	chma_ram #(.WIDTH(16), .DEPTH(WINDOW_LEN)) u_ram (
		.clk   (clk),
		.we    (en && v_s1),
		.waddr (ptr_s1),
		.wdata (h_s1),
		.re    (en && in_vld),
		.raddr (ptr_q),
		.rdata (old_data)
	);

	// forward when the read hits the entry being written this cycle
	logic fwd_s1_q;
	logic [15:0] h_fwd_q;
	logic [15:0] old_eff;
	assign old_eff = fwd_s1_q ? h_fwd_q : old_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ptr_q    <= '0;
			v_s1     <= 1'b0;
			fwd_s1_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			fwd_s1_q <= in_vld && v_s1 && (ptr_s1 == ptr_q);
			if (in_vld) begin
				if (!full) fill_q <= fill_q + 1'b1;
				ptr_q <= (ptr_q == WIN_AW'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1    <= in_heading;
			full_s1 <= full;
			ptr_s1  <= ptr_q;
			h_fwd_q <= h_s1;
		end
	end

	// stage 2: update running sum
	logic [SUM_W-1:0] sum_new;
	assign sum_new = sum_q + SUM_W'(h_s1) - (full_s1 ? SUM_W'(old_eff) : '0);

	logic             v_s2, full_s2;
	logic [15:0]      h_s2;
	logic [SUM_W-1:0] num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v_s2  <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			if (v_s1) sum_q <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s2    <= h_s1;
			full_s2 <= full_s1;
			num_s2  <= sum_new + SUM_W'(WINDOW_LEN / 2);
		end
	end

	// stage 3: multiply by reciprocal
	logic             v_s3, full_s3;
	logic [15:0]      h_s3;
	logic [SUM_W-1:0] num_s3;
	logic [SUM_W+32:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s3    <= h_s2;
			full_s3 <= full_s2;
			num_s3  <= num_s2;
			prod_s3 <= (SUM_W+33)'(num_s2) * (SUM_W+33)'(RECIP);
		end
	end

	// stage 4: correct the quotient estimate by one
	logic [SUM_W-1:0] q_est, rem;
	logic [15:0]      mean;
	always_comb begin
		q_est = prod_s3[RECIP_SH +: SUM_W];
		rem   = num_s3 - SUM_W'(q_est * SUM_W'(WINDOW_LEN));
		mean  = (rem >= SUM_W'(WINDOW_LEN)) ? 16'(q_est + 1'b1) : 16'(q_est);
	end

	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d.heading      <= h_s3;
			out_d.mean_heading <= full_s3 ? mean : '0;
			out_d.mean_valid   <= full_s3;
		end
	end

	assign out_vld = v_s4;

endmodule
`default_nettype wire

// ===== hw/rtl/chma_checker.sv =====
`default_nettype none
module chma_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire chma_pkg::out_t out_data
);
	import chma_pkg::*;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// heading in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.heading < FULL_CIRCLE)
		else $error("heading out of range");

	// mean is zero while invalid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.mean_valid |-> out_data.mean_heading == 16'd0)
		else $error("mean nonzero during fill");

	// stalled output blocks new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while output stalled");

	// once valid, the mean stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.mean_valid ##1 out_valid
		|-> out_data.mean_valid)
		else $error("mean valid dropped");

endmodule

bind compass_heading_moving_average chma_checker u_chma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// ===== verif/compass_heading_moving_average_tb.sv =====
`timescale 1ns / 100ps
module compass_heading_moving_average_tb;
	import chma_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	compass_heading_moving_average i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// atan(2^-i) in 1/32768 degree, own copy
	localparam longint ATAN_FINE [0:23] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
		7334, 3667, 1833, 917, 458, 229, 115, 57,
		29, 14, 7, 4, 2, 1, 0, 0
	};

	// predictor state
	logic [15:0] win_hist [0:WINDOW_LEN-1];
	int unsigned win_fill;
	int unsigned win_total;

	out_t expected_q [$];
	int   mismatches;
	int   sender_idle;
	int   receiver_idle;

	// directed table: x, y, heading typed in where obvious (-1 means predicted)
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		int                 hdg;
	} row_t;

	row_t rows [$];

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// first quadrant angle via vectoring cordic, 1/128 degree
	function automatic int unsigned first_quad_angle(longint ax, longint ay);
		longint xr, yr, zr, dx, dy;
		xr = ax * 256;
		yr = ay * 256;
		zr = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = floor_shift(yr, i);
			dy = floor_shift(xr, i);
			if (yr >= 0) begin
				xr += dx; yr -= dy; zr += ATAN_FINE[i];
			end else begin
				xr -= dx; yr += dy; zr -= ATAN_FINE[i];
			end
		end
		if (zr < 0) zr = 0;
		if (zr > 2949120) zr = 2949120;
		return int'((zr + 128) >>> 8);
	endfunction

	function automatic logic [15:0] heading_of(logic signed [15:0] mx, logic signed [15:0] my);
		int unsigned a, h;
		longint ax, ay;
		if (mx == 0 && my == 0) return 16'd0;
		if (mx == 0) return (my > 0) ? QUARTER : THREE_QUARTER;
		if (my == 0) return (mx > 0) ? 16'd0 : HALF_CIRCLE;
		ax = (mx < 0) ? -longint'(mx) : longint'(mx);
		ay = (my < 0) ? -longint'(my) : longint'(my);
		a = first_quad_angle(ax, ay);
		if (mx > 0 && my > 0) h = a;
		else if (mx < 0 && my > 0) h = HALF_CIRCLE - a;
		else if (mx < 0) h = HALF_CIRCLE + a;
		else h = FULL_CIRCLE - a;
		if (h >= FULL_CIRCLE) h -= FULL_CIRCLE;
		return h[15:0];
	endfunction

	// advance the window and queue the expected result
	task automatic predict_heading(in_t req);
		out_t r;
		r.heading = heading_of(req.mag_x, req.mag_y);
		r.mean_heading = '0;
		r.mean_valid = 1'b0;
		if (win_fill < WINDOW_LEN) begin
			win_hist[win_fill] = r.heading;
			win_total += r.heading;
			win_fill++;
		end else begin
			win_total -= win_hist[0];
			for (int i = 0; i < WINDOW_LEN - 1; i++) win_hist[i] = win_hist[i+1];
			win_hist[WINDOW_LEN-1] = r.heading;
			win_total += r.heading;
			r.mean_heading = 16'((win_total + WINDOW_LEN / 2) / WINDOW_LEN);
			r.mean_valid = 1'b1;
		end
		expected_q.push_back(r);
	endtask

	task automatic note_mismatch(out_t exp_r, out_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
				exp_r.heading, exp_r.mean_heading, exp_r.mean_valid,
				got.heading, got.mean_heading, got.mean_valid);
	endtask

	// send one request, holding valid until accepted
	task automatic send_request(logic signed [15:0] x, logic signed [15:0] y);
		while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.mag_x <= x;
		in_data.mag_y <= y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_heading('{mag_x: x, mag_y: y});
		@(negedge clk);
	endtask

	// random sample, biased toward small values, axes and extremes
	task automatic send_random();
		logic signed [15:0] x, y;
		int sel;
		sel = $urandom_range(9);
		x = $urandom;
		y = $urandom;
		if (sel == 0) x = 0;
		else if (sel == 1) y = 0;
		else if (sel == 2) begin
			x = $signed(16'($urandom_range(64))) - 16'sd32;
			y = $signed(16'($urandom_range(64))) - 16'sd32;
		end else if (sel == 3) begin
			x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		end
		send_request(x, y);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stall, compare at the rising edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= !(receiver_idle > 0 && $urandom_range(99) < receiver_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d", out_data.heading);
			end else begin
				out_t exp_r;
				exp_r = expected_q.pop_front();
				if (out_data !== exp_r) note_mismatch(exp_r, out_data);
			end
		end
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		row_t r;
		int wait_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		mismatches = 0;
		win_fill = 0;
		win_total = 0;
		sender_idle = 0;
		receiver_idle = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows: axes, zero vector, extremes, each quadrant
		rows = '{
			'{16'sd0, 16'sd0, 0}, '{16'sd1, 16'sd0, 0}, '{-16'sd1, 16'sd0, 23040},
			'{16'sd0, 16'sd1, 11520}, '{16'sd0, -16'sd1, 34560},
			'{16'sh7fff, 16'sd0, 0}, '{16'sh8000, 16'sd0, 23040},
			'{16'sd0, 16'sh7fff, 11520}, '{16'sd0, 16'sh8000, 34560},
			'{16'sh7fff, 16'sh7fff, -1}, '{16'sh8000, 16'sh7fff, -1},
			'{16'sh8000, 16'sh8000, -1}, '{16'sh7fff, 16'sh8000, -1},
			'{16'sd1, 16'sd1, -1}, '{-16'sd1, 16'sd1, -1}, '{-16'sd1, -16'sd1, -1},
			'{16'sd1, -16'sd1, -1}, '{16'sh7fff, 16'sd1, -1}, '{16'sd1, 16'sh7fff, -1},
			'{16'sd1, 16'sh8000, -1}, '{16'sh8000, -16'sd1, -1},
			'{16'sd300, -16'sd1, -1}, '{-16'sd5, 16'sd1200, -1}
		};
		foreach (rows[i]) begin
			r = rows[i];
			send_request(r.x, r.y);
			if (r.hdg >= 0 && expected_q[$].heading != 16'(r.hdg))
				note_mismatch('{heading: 16'(r.hdg), mean_heading: 0, mean_valid: 0},
					expected_q[$]);
		end

		// random phases with different idling
		for (int p = 0; p < 3; p++) begin
			sender_idle = (p == 0) ? 15 : (p == 1) ? 88 : 0;
			receiver_idle = (p == 0) ? 88 : (p == 1) ? 15 : 0;
			repeat (370) send_random();
		end
		receiver_idle = 0;
		in_valid <= 1'b0;

		// drain
		wait_cycles = 0;
		while (expected_q.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (CORDIC_STEPS + 20) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
